// ===== hdl/zcdw_pkg.sv =====
`default_nettype none
package zcdw_pkg;

    // fixed header layout of one central directory entry
    localparam int unsigned HDR_LEN     = 46;
    localparam int unsigned OFF_CRC     = 16;
    localparam int unsigned OFF_CSIZE   = 20;
    localparam int unsigned OFF_SIZE    = 24;
    localparam int unsigned OFF_NAME    = 28;
    localparam int unsigned OFF_EXTRA   = 30;
    localparam int unsigned OFF_COMMENT = 32;

    localparam int unsigned POS_W   = 6;
    localparam int unsigned SKIP_W  = 18;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ADDR_W  = 2;

    // register map
    localparam logic [ADDR_W-1:0] REG_ENTRY_TOTAL = 2'd0;

    // one finished entry
    typedef struct packed {
        logic [COUNT_W-1:0] entry_index;
        logic [WORD_W-1:0]  uncompressed_size;
        logic [WORD_W-1:0]  compressed_size;
        logic [WORD_W-1:0]  entry_crc;
        logic [WORD_W-1:0]  size_sum;
        logic               last_entry;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/zip_central_directory_walker.sv =====
// Each finished entry's result is registered into the output register behind o_out_valid, or into the skid buffer.
// Throughput: one directory byte per cycle, sustained, while the output side keeps up.
// A one-entry skid buffer behind the output register takes one more result while a
// result waits; o_in_ready drops only when both hold a result.
// Reset (synchronous, i_rst_n low) clears all counters, captured fields, entry_total
// and both output stages; the walk then starts as on a first byte.
`default_nettype none
module zip_central_directory_walker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // byte input channel
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [7:0]                   i_data_byte,
    input  wire                          i_first,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [zcdw_pkg::COUNT_W-1:0] o_entry_index,
    output logic [zcdw_pkg::WORD_W-1:0]  o_uncompressed_size,
    output logic [zcdw_pkg::WORD_W-1:0]  o_compressed_size,
    output logic [zcdw_pkg::WORD_W-1:0]  o_entry_crc,
    output logic [zcdw_pkg::WORD_W-1:0]  o_size_sum,
    output logic                         o_last_entry,
    // APB configuration port
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire  [zcdw_pkg::ADDR_W-1:0]  i_paddr,
    input  wire  [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready
);
    import zcdw_pkg::*;

    // configuration
    logic [COUNT_W-1:0] r_total;

    // walk state
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [SKIP_W-1:0]  r_skip,  n_skip;
    logic [LEN_W-1:0]   r_name,  n_name;
    logic [LEN_W-1:0]   r_extra, n_extra;
    logic [LEN_W-1:0]   r_cmt,   n_cmt;
    logic [WORD_W-1:0]  r_size,  n_size;
    logic [WORD_W-1:0]  r_csize, n_csize;
    logic [WORD_W-1:0]  r_crc,   n_crc;
    logic [COUNT_W-1:0] r_done,  n_done;
    logic [WORD_W-1:0]  r_sum,   n_sum;

    // output register and skid stage
    logic    r_ov, r_sv;
    t_result r_out, r_skid;
    t_result n_res;
    logic    n_res_v;

    logic in_acc, out_pop, cfg_wr;

    logic [POS_W-1:0]   pos_b, pos_inc;
    logic [SKIP_W-1:0]  skip_b, skip_new;
    logic [COUNT_W-1:0] done_b;
    logic [WORD_W-1:0]  sum_b;
    logic [7:0]         b;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_pop = r_ov && i_out_ready;
    assign cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;

    assign o_in_ready = !r_sv;
    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr == REG_ENTRY_TOTAL) ? {16'd0, r_total} : 32'd0;

    assign o_out_valid         = r_ov;
    assign o_entry_index       = r_out.entry_index;
    assign o_uncompressed_size = r_out.uncompressed_size;
    assign o_compressed_size   = r_out.compressed_size;
    assign o_entry_crc         = r_out.entry_crc;
    assign o_size_sum          = r_out.size_sum;
    assign o_last_entry        = r_out.last_entry;

    // per-byte walk: capture header fields, count trailers, finish entries
    always_comb begin
        n_pos   = r_pos;
        n_skip  = r_skip;
        n_name  = r_name;
        n_extra = r_extra;
        n_cmt   = r_cmt;
        n_size  = r_size;
        n_csize = r_csize;
        n_crc   = r_crc;
        n_done  = r_done;
        n_sum   = r_sum;
        n_res_v = 1'b0;
        n_res   = '0;
        b        = i_data_byte;
        pos_b    = i_first ? '0 : r_pos;
        skip_b   = i_first ? '0 : r_skip;
        done_b   = i_first ? '0 : r_done;
        sum_b    = i_first ? '0 : r_sum;
        pos_inc  = pos_b + POS_W'(1);
        skip_new = '0;

        if (in_acc) begin
            // restart clears the walk even when the byte is then ignored
            n_pos  = pos_b;
            n_skip = skip_b;
            n_done = done_b;
            n_sum  = sum_b;

            if (done_b < r_total) begin
                if (pos_b < POS_W'(HDR_LEN)) begin
                    // little-endian field capture by header offset
                    if (pos_b >= POS_W'(OFF_CRC) && pos_b < POS_W'(OFF_CRC + 4)) begin
                        n_crc[pos_b[1:0]*8 +: 8] = b;
                    end else if (pos_b >= POS_W'(OFF_CSIZE) &&
                                 pos_b < POS_W'(OFF_CSIZE + 4)) begin
                        n_csize[pos_b[1:0]*8 +: 8] = b;
                    end else if (pos_b >= POS_W'(OFF_SIZE) &&
                                 pos_b < POS_W'(OFF_SIZE + 4)) begin
                        n_size[pos_b[1:0]*8 +: 8] = b;
                    end else if (pos_b >= POS_W'(OFF_NAME) &&
                                 pos_b < POS_W'(OFF_NAME + 2)) begin
                        n_name[pos_b[0]*8 +: 8] = b;
                    end else if (pos_b >= POS_W'(OFF_EXTRA) &&
                                 pos_b < POS_W'(OFF_EXTRA + 2)) begin
                        n_extra[pos_b[0]*8 +: 8] = b;
                    end else if (pos_b >= POS_W'(OFF_COMMENT) &&
                                 pos_b < POS_W'(OFF_COMMENT + 2)) begin
                        n_cmt[pos_b[0]*8 +: 8] = b;
                    end
                    n_pos = pos_inc;
                    if (pos_inc == POS_W'(HDR_LEN)) begin
                        skip_new = SKIP_W'(r_name) + SKIP_W'(r_extra) + SKIP_W'(r_cmt);
                        n_skip   = skip_new;
                        n_res_v  = (skip_new == '0);
                    end
                end else begin
                    // trailing name, extra and comment bytes
                    skip_new = (skip_b != '0) ? skip_b - SKIP_W'(1) : skip_b;
                    n_skip   = skip_new;
                    n_res_v  = (skip_new == '0);
                end

                // entry complete
                if (n_res_v) begin
                    n_sum = sum_b + n_size;
                    n_res.entry_index       = done_b;
                    n_res.uncompressed_size = n_size;
                    n_res.compressed_size   = n_csize;
                    n_res.entry_crc         = n_crc;
                    n_res.size_sum          = sum_b + n_size;
                    n_res.last_entry        = ({1'b0, done_b} + 17'd1) == {1'b0, r_total};
                    n_done = done_b + COUNT_W'(1);
                    n_pos  = '0;
                    n_skip = '0;
                end
            end
        end
    end

    // walk state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_pos   <= '0;
            r_skip  <= '0;
            r_name  <= '0;
            r_extra <= '0;
            r_cmt   <= '0;
            r_size  <= '0;
            r_csize <= '0;
            r_crc   <= '0;
            r_done  <= '0;
            r_sum   <= '0;
        end else begin
            if (cfg_wr && i_paddr == REG_ENTRY_TOTAL) begin
                r_total <= i_pwdata[COUNT_W-1:0];
            end
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_name  <= n_name;
            r_extra <= n_extra;
            r_cmt   <= n_cmt;
            r_size  <= n_size;
            r_csize <= n_csize;
            r_crc   <= n_crc;
            r_done  <= n_done;
            r_sum   <= n_sum;
        end
    end

    // output register with one-beat skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_pop) begin
                r_sv <= 1'b0;
            end
        end else if (out_pop || !r_ov) begin
            r_ov <= n_res_v;
        end else if (n_res_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (out_pop || !r_ov) begin
            if (n_res_v) begin
                r_out <= n_res;
            end
        end else if (n_res_v) begin
            r_skid <= n_res;
        end
    end

    // checks
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a beat while the output register is empty");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(HDR_LEN))
        else $error("header position past the fixed header");

    a_skip_in_trailer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> (r_pos == POS_W'(HDR_LEN)))
        else $error("trailer count pending outside the trailer phase");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_out_ready) |=> (r_sv && !o_in_ready))
        else $error("skid beat lost under back-pressure");

endmodule
`default_nettype wire
